// ===== src/playfair_ascii_grid_cipher_macros.svh =====
// Assertion macros shared by the playfair grid cipher RTL.
`ifndef PLAYFAIR_ASCII_GRID_CIPHER_MACROS_SVH
`define PLAYFAIR_ASCII_GRID_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside of reset.
`define PFGC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside of reset.
`define PFGC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

// ===== src/pfgc_pkg.sv =====
// Shared constants, codes and types of the playfair grid cipher.
package pfgc_pkg;

   // Grid geometry.
   localparam int GRID_ROWS  = 10;
   localparam int GRID_COLS  = 10;
   localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int FILL_W     = $clog2(CELL_COUNT + 1);
   localparam int ROW_W      = $clog2(GRID_ROWS);
   localparam int COL_W      = $clog2(GRID_COLS);

   // Character codes.
   localparam int CHAR_W     = 7;
   localparam int CODE_COUNT = 128;
   localparam logic [CHAR_W-1:0] FIRST_PRINT = 7'd32;
   localparam logic [CHAR_W-1:0] LAST_PRINT  = 7'd126;
   localparam logic [CHAR_W-1:0] PAD_CHAR    = 7'h78;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

   // Operation codes of an input beat.
   localparam logic [1:0] OP_KEY     = 2'd0;
   localparam logic [1:0] OP_FINISH  = 2'd1;
   localparam logic [1:0] OP_ENCRYPT = 2'd2;
   localparam logic [1:0] OP_DECRYPT = 2'd3;

   // Grid position of one character.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } pos_type;

   // Placement of one character, broadcast to every lane.
   typedef struct packed {
      logic              en;
      logic [CELL_W-1:0] slot;
      logic [CHAR_W-1:0] code;
      pos_type           pos;
   } write_type;

   // One result beat.
   typedef struct packed {
      logic [CHAR_W-1:0] out_a;
      logic [CHAR_W-1:0] out_b;
      logic [1:0]        out_count;
      logic              out_last;
   } result_type;

endpackage

// ===== src/playfair_ascii_grid_cipher.sv =====
// Playfair cipher over a grid of printable ASCII: one lane per pair character.
//
// Key characters (op 0) are taken one per cycle while the input is not held
// off and fill the grid in row-major order; a finish beat (op 1) then walks
// the codes 32..126 one per cycle, so it holds off the input until the walk
// is done. An encrypt or decrypt pair passes through a position lookup in
// the per-lane position memories and then a read of the grid memory, and the
// next pair can be taken once the result of the one before is handed off.
// A result waits in an output register, which does not hold off the next
// input beat until a second result is ready. Key and finish beats give no
// result. Reset clears the control state and the used flags; unwritten
// memory entries are masked on read, so no clearing pass is needed.
`include "playfair_ascii_grid_cipher_macros.svh"

module playfair_ascii_grid_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [pfgc_pkg::CHAR_W-1:0]   req_char_a,
   input  logic [pfgc_pkg::CHAR_W-1:0]   req_char_b,
   input  logic                          req_b_present,
   input  logic                          req_last_pair,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pfgc_pkg::CHAR_W-1:0]   rsp_out_a,
   output logic [pfgc_pkg::CHAR_W-1:0]   rsp_out_b,
   output logic [1:0]                    rsp_out_count,
   output logic                          rsp_out_last
);
   import pfgc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;
   localparam logic [1:0] ST_FILL = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CHAR_W-1:0]     scan_ff, scan_in;
   logic [FILL_W-1:0]     fill_ff;
   logic [ROW_W-1:0]      frow_ff;
   logic [COL_W-1:0]      fcol_ff;
   logic [CODE_COUNT-1:0] used_ff;
   logic                  dec_ff;
   logic                  last_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;

   logic              accept;
   logic              is_pair;
   logic              out_busy;
   logic              load_out;
   logic              full;
   logic              key_place;
   logic              scan_place;
   logic              place_en;
   logic [CHAR_W-1:0] place_code;
   logic [CHAR_W-1:0] code_b;
   logic [1:0]        op_state;
   write_type         wr;
   pos_type           pos_a, pos_b;
   logic [CELL_W-1:0] cell_a, cell_b;
   logic [CHAR_W-1:0] data_a, data_b;
   result_type        result;

   // Input handshake.
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff == ST_ADDR) || (state_ff == ST_FILL)
                   || ((state_ff == ST_DATA) && out_busy);
   assign accept    = req_valid && !req_stall;
   assign is_pair   = (req_op == OP_ENCRYPT) || (req_op == OP_DECRYPT);
   assign code_b    = req_b_present ? req_char_b : PAD_CHAR;

   // Placement of a key character or of a code found unused by the finish walk.
   assign full       = fill_ff == FILL_W'(CELL_COUNT);
   assign key_place  = accept && (req_op == OP_KEY)
                    && (req_char_a inside {[FIRST_PRINT:LAST_PRINT]})
                    && !used_ff[req_char_a];
   assign scan_place = (state_ff == ST_FILL) && !used_ff[scan_ff];
   assign place_en   = (key_place || scan_place) && !full;
   assign place_code = (state_ff == ST_FILL) ? scan_ff : req_char_a;

   assign wr.en   = place_en;
   assign wr.slot = fill_ff[CELL_W-1:0];
   assign wr.code = place_code;
   assign wr.pos  = '{row: frow_ff, col: fcol_ff};

   // Fill pointer and used flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         frow_ff <= '0;
         fcol_ff <= '0;
         used_ff <= '0;
      end else if (place_en) begin
         fill_ff             <= fill_ff + FILL_W'(1);
         used_ff[place_code] <= 1'b1;
         if (fcol_ff == LAST_COL) begin
            fcol_ff <= '0;
            frow_ff <= frow_ff + ROW_W'(1);
         end else begin
            fcol_ff <= fcol_ff + COL_W'(1);
         end
      end
   end

   // Next state for a beat taken this cycle.
   always_comb begin
      case (req_op)
         OP_KEY:    op_state = ST_IDLE;
         OP_FINISH: op_state = ST_FILL;
         default:   op_state = ST_ADDR;
      endcase
   end

   // Sequencer: lookup, grid read, result hand-off, finish walk.
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = op_state;
            end
         end
         ST_ADDR: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (!out_busy) begin
               load_out = 1'b1;
               state_in = accept ? op_state : ST_IDLE;
            end
         end
         ST_FILL: begin
            scan_in = scan_ff + CHAR_W'(1);
            if (scan_ff == LAST_PRINT) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept && (req_op == OP_FINISH)) begin
         scan_in = FIRST_PRINT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= FIRST_PRINT;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   // Pair attributes travel with the pair to the result.
   always_ff @(posedge clock) begin
      if (accept && is_pair) begin
         dec_ff  <= req_op == OP_DECRYPT;
         last_ff <= req_last_pair;
      end
   end

   // Lane A looks up the first character, lane B the second.
   pfgc_lane u_lane_a (
      .clock      (clock),
      .wr         (wr),
      .look_en    (accept && is_pair),
      .look_code  (req_char_a),
      .look_hit   (used_ff[req_char_a]),
      .pos        (pos_a),
      .read_en    (state_ff == ST_ADDR),
      .read_cell  (cell_a),
      .fill_count (fill_ff),
      .cell_data  (data_a)
   );

   pfgc_lane u_lane_b (
      .clock      (clock),
      .wr         (wr),
      .look_en    (accept && is_pair),
      .look_code  (code_b),
      .look_hit   (used_ff[code_b]),
      .pos        (pos_b),
      .read_en    (state_ff == ST_ADDR),
      .read_cell  (cell_b),
      .fill_count (fill_ff),
      .cell_data  (data_b)
   );

   pfgc_merge u_merge (
      .pos_a  (pos_a),
      .pos_b  (pos_b),
      .dec    (dec_ff),
      .last   (last_ff),
      .cell_a (cell_a),
      .cell_b (cell_b),
      .data_a (data_a),
      .data_b (data_b),
      .result (result)
   );

   // Output register holds a result beat until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_a     = rsp_ff.out_a;
   assign rsp_out_b     = rsp_ff.out_b;
   assign rsp_out_count = rsp_ff.out_count;
   assign rsp_out_last  = rsp_ff.out_last;

   // Checks on the sequencer and the fill logic.
   `PFGC_ASSERT_NEXT(a_pair_reaches_data, accept && is_pair,
      ##1 (state_ff == ST_DATA), "pair did not reach the grid read stage")
   `PFGC_ASSERT_NEXT(a_place_advances, place_en,
      (fill_ff == $past(fill_ff) + FILL_W'(1)) && used_ff[$past(place_code)],
      "placement did not advance the fill pointer")
   `PFGC_ASSERT_NOW(a_fill_bound, 1'b1, (fill_ff <= FILL_W'(CELL_COUNT)),
      "fill pointer ran past the grid")
   `PFGC_ASSERT_NOW(a_result_source, $rose(rsp_valid_ff), ($past(state_ff) == ST_DATA),
      "result appeared outside the hand-off stage")
   `PFGC_ASSERT_NOW(a_drop_only_last, rsp_valid_ff && (rsp_out_count == 2'd1),
      (rsp_out_last && (rsp_out_b == '0)), "character dropped outside the last pair")

endmodule

// ===== src/pfgc_lane.sv =====
// One lookup lane: a copy of the position and grid memories with its own read ports.
module pfgc_lane (
   input  logic                          clock,
   input  pfgc_pkg::write_type           wr,
   input  logic                          look_en,
   input  logic [pfgc_pkg::CHAR_W-1:0]   look_code,
   input  logic                          look_hit,
   output pfgc_pkg::pos_type             pos,
   input  logic                          read_en,
   input  logic [pfgc_pkg::CELL_W-1:0]   read_cell,
   input  logic [pfgc_pkg::FILL_W-1:0]   fill_count,
   output logic [pfgc_pkg::CHAR_W-1:0]   cell_data
);
   import pfgc_pkg::*;

   pos_type           pos_mem_ff  [CODE_COUNT];
   logic [CHAR_W-1:0] grid_mem_ff [CELL_COUNT];

   pos_type           pos_q_ff;
   logic              hit_ff;
   logic [CHAR_W-1:0] data_q_ff;
   logic              filled_ff;

   // Every lane takes the same placements, so all copies stay equal.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         pos_mem_ff[wr.code]  <= wr.pos;
         grid_mem_ff[wr.slot] <= wr.code;
      end
   end

   // Position lookup; a code never placed reads as row 0, column 0.
   always_ff @(posedge clock) begin
      if (look_en) begin
         pos_q_ff <= pos_mem_ff[look_code];
         hit_ff   <= look_hit;
      end
   end

   assign pos = hit_ff ? pos_q_ff : '0;

   // Grid read; cells beyond the fill count have never been written and read as 0.
   always_ff @(posedge clock) begin
      if (read_en) begin
         data_q_ff <= grid_mem_ff[read_cell];
         filled_ff <= FILL_W'(read_cell) < fill_count;
      end
   end

   assign cell_data = filled_ff ? data_q_ff : '0;

endmodule

// ===== src/pfgc_merge.sv =====
// Combines the two lanes: picks the cells to read from the pair rules and forms the result.
module pfgc_merge (
   input  pfgc_pkg::pos_type             pos_a,
   input  pfgc_pkg::pos_type             pos_b,
   input  logic                          dec,
   input  logic                          last,
   output logic [pfgc_pkg::CELL_W-1:0]   cell_a,
   output logic [pfgc_pkg::CELL_W-1:0]   cell_b,
   input  logic [pfgc_pkg::CHAR_W-1:0]   data_a,
   input  logic [pfgc_pkg::CHAR_W-1:0]   data_b,
   output pfgc_pkg::result_type          result
);
   import pfgc_pkg::*;

   pos_type tgt_a;
   pos_type tgt_b;

   function automatic logic [COL_W-1:0] col_step(logic [COL_W-1:0] c, logic back);
      if (back) begin
         return (c == '0) ? LAST_COL : c - COL_W'(1);
      end
      return (c == LAST_COL) ? '0 : c + COL_W'(1);
   endfunction

   function automatic logic [ROW_W-1:0] row_step(logic [ROW_W-1:0] r, logic back);
      if (back) begin
         return (r == '0) ? LAST_ROW : r - ROW_W'(1);
      end
      return (r == LAST_ROW) ? '0 : r + ROW_W'(1);
   endfunction

   function automatic logic [CELL_W-1:0] cell_of(pos_type p);
      return CELL_W'(p.row) * CELL_W'(GRID_COLS) + CELL_W'(p.col);
   endfunction

   // Same row shifts along the row, same column along the column, else swap corners.
   always_comb begin
      if (pos_a.row == pos_b.row) begin
         tgt_a = '{row: pos_a.row, col: col_step(pos_a.col, dec)};
         tgt_b = '{row: pos_b.row, col: col_step(pos_b.col, dec)};
      end else if (pos_a.col == pos_b.col) begin
         tgt_a = '{row: row_step(pos_a.row, dec), col: pos_a.col};
         tgt_b = '{row: row_step(pos_b.row, dec), col: pos_b.col};
      end else begin
         tgt_a = '{row: pos_a.row, col: pos_b.col};
         tgt_b = '{row: pos_b.row, col: pos_a.col};
      end
   end

   assign cell_a = cell_of(tgt_a);
   assign cell_b = cell_of(tgt_b);

   // A trailing pad character on the last decrypted pair is dropped.
   always_comb begin
      result.out_a     = data_a;
      result.out_b     = data_b;
      result.out_count = 2'd2;
      result.out_last  = last;
      if (dec && last && data_b == PAD_CHAR) begin
         result.out_b     = '0;
         result.out_count = 2'd1;
      end
   end

endmodule
